[design/ragr_pkg.sv]
`timescale 1ns / 1ps
package ragr_pkg;

	localparam int OperandWidth = 32;
	localparam int MagWidth     = 64;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_RED = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [62:0]        res_den;
		logic               den_zero;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL1,
		CMD_MUL2,
		CMD_SUM,
		CMD_GCD_STEP,
		CMD_DIVN_INIT,
		CMD_DIV_STEP,
		CMD_DIVD_INIT,
		CMD_FIN
	} cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_done;
	} status_t;

endpackage

[design/ragr_ctrl.sv]
`timescale 1ns / 1ps
module ragr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ragr_pkg::status_t status,
	output ragr_pkg::cmd_t    cmd
);

	ragr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ragr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = ragr_pkg::CMD_NONE;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ragr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd     = ragr_pkg::CMD_LOAD;
					state_d = ragr_pkg::ST_MUL1;
				end
			end
			ragr_pkg::ST_MUL1: begin
				cmd     = ragr_pkg::CMD_MUL1;
				state_d = ragr_pkg::ST_MUL2;
			end
			ragr_pkg::ST_MUL2: begin
				cmd     = ragr_pkg::CMD_MUL2;
				state_d = ragr_pkg::ST_SUM;
			end
			ragr_pkg::ST_SUM: begin
				cmd     = ragr_pkg::CMD_SUM;
				state_d = ragr_pkg::ST_GCD;
			end
			ragr_pkg::ST_GCD: begin
				if (status.gcd_done) begin
					cmd     = ragr_pkg::CMD_DIVN_INIT;
					state_d = ragr_pkg::ST_DIVN;
				end else begin
					cmd = ragr_pkg::CMD_GCD_STEP;
				end
			end
			ragr_pkg::ST_DIVN: begin
				if (status.div_done) begin
					cmd     = ragr_pkg::CMD_DIVD_INIT;
					state_d = ragr_pkg::ST_DIVD;
				end else begin
					cmd = ragr_pkg::CMD_DIV_STEP;
				end
			end
			ragr_pkg::ST_DIVD: begin
				if (status.div_done) begin
					state_d = ragr_pkg::ST_FIN;
				end else begin
					cmd = ragr_pkg::CMD_DIV_STEP;
				end
			end
			ragr_pkg::ST_FIN: begin
				cmd     = ragr_pkg::CMD_FIN;
				state_d = ragr_pkg::ST_OUT;
			end
			ragr_pkg::ST_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd     = ragr_pkg::CMD_LOAD;
						state_d = ragr_pkg::ST_MUL1;
					end else begin
						state_d = ragr_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = ragr_pkg::ST_IDLE;
		endcase
	end

endmodule

[design/ragr_dp.sv]
`timescale 1ns / 1ps
module ragr_dp #(
	parameter int OPERAND_WIDTH = ragr_pkg::OperandWidth
) (
	input  logic                clk,
	input  ragr_pkg::in_item_t  in_item,
	input  ragr_pkg::cmd_t      cmd,
	output ragr_pkg::status_t   status,
	output ragr_pkg::out_item_t out_item
);

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = ragr_pkg::MagWidth;
	localparam int CW = $clog2(MW + 1);

	logic [2:0]     op_q;
	logic [W-1:0]   an_q, ad_q, bn_q, bd_q;
	logic           ann_q, adn_q, bnn_q, bdn_q;
	logic [MW-1:0]  p1_q, p2_q;
	logic           p1n_q, p2n_q;
	logic [MW-1:0]  nmag_q, dmag_q;
	logic           nneg_q, dneg_q;
	logic [MW-1:0]  ga_q, gb_q;
	logic [CW-1:0]  gk_q;
	logic [MW-1:0]  quo_q, rem_q, dvd_q, nres_q;
	logic [CW-1:0]  cnt_q;
	ragr_pkg::out_item_t out_q;

	function automatic logic [W-1:0] mag_of(input logic [31:0] raw);
		logic [W-1:0] v;
		v = raw[W-1:0];
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	// shared multiplier: first numerator product, second product, then ad * bd in the sum step
	logic [W-1:0]      mx, my;
	logic [2*W-1:0]    prod;
	always_comb begin
		mx = ad_q;
		my = bd_q;
		case (cmd)
			ragr_pkg::CMD_MUL1: begin
				mx = an_q;
				my = (op_q == ragr_pkg::OP_MUL) ? bn_q : bd_q;
			end
			ragr_pkg::CMD_MUL2: begin
				mx = ad_q;
				my = (op_q == ragr_pkg::OP_MUL) ? bd_q : bn_q;
			end
			default: begin
				mx = ad_q;
				my = bd_q;
			end
		endcase
		prod = mx * my;
	end

	// sum step
	logic [MW-1:0] s_mag;
	logic          s_neg, t_neg;
	always_comb begin
		t_neg = p2n_q ^ (op_q == ragr_pkg::OP_SUB);
		if (p1n_q == t_neg) begin
			s_mag = p1_q + p2_q;
			s_neg = p1n_q;
		end else if (p1_q >= p2_q) begin
			s_mag = p1_q - p2_q;
			s_neg = p1n_q;
		end else begin
			s_mag = p2_q - p1_q;
			s_neg = t_neg;
		end
		if (s_mag == '0) s_neg = 1'b0;
	end

	// restoring divider step
	logic [MW:0]   rtry;
	logic [MW-1:0] rsh;
	always_comb begin
		rsh  = {rem_q[MW-2:0], dvd_q[MW-1]};
		rtry = {rem_q[MW-1], rsh} - {1'b0, ga_q};
	end

	// GCD once one side has reached zero, with the common power of two restored
	logic [MW-1:0] gsh;
	assign gsh = (ga_q | gb_q) << gk_q;

	assign status.gcd_done = (ga_q == '0) || (gb_q == '0);
	assign status.div_done = (cnt_q == '0);

	logic [MW-1:0] fn, fd;
	logic          fneg;
	always_comb begin
		fn = nres_q;
		fd = quo_q;
		if (fn == '0) fneg = 1'b0;
		else if (fd == '0) fneg = nneg_q;
		else fneg = nneg_q ^ dneg_q;
		if (fn == '0 && fd != '0) fd = MW'(1);
		if (fn[MW-1]) fn = {1'b0, {(MW-1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		case (cmd)
			ragr_pkg::CMD_LOAD: begin
				op_q  <= in_item.op;
				an_q  <= mag_of(in_item.a_num);
				ad_q  <= mag_of(in_item.a_den);
				bn_q  <= mag_of(in_item.b_num);
				bd_q  <= mag_of(in_item.b_den);
				ann_q <= in_item.a_num[W-1];
				adn_q <= in_item.a_den[W-1];
				bnn_q <= in_item.b_num[W-1];
				bdn_q <= in_item.b_den[W-1];
			end
			ragr_pkg::CMD_MUL1: begin
				p1_q  <= MW'(prod);
				p1n_q <= (op_q == ragr_pkg::OP_MUL) ? (ann_q ^ bnn_q) : (ann_q ^ bdn_q);
			end
			ragr_pkg::CMD_MUL2: begin
				p2_q  <= MW'(prod);
				p2n_q <= (op_q == ragr_pkg::OP_MUL) ? (adn_q ^ bdn_q) : (adn_q ^ bnn_q);
			end
			ragr_pkg::CMD_SUM: begin
				case (op_q)
					ragr_pkg::OP_ADD, ragr_pkg::OP_SUB: begin
						nmag_q <= s_mag;      nneg_q <= s_neg;
						dmag_q <= MW'(prod);  dneg_q <= adn_q ^ bdn_q;
					end
					ragr_pkg::OP_MUL, ragr_pkg::OP_DIV: begin
						nmag_q <= p1_q; nneg_q <= p1n_q;
						dmag_q <= p2_q; dneg_q <= p2n_q;
					end
					default: begin
						nmag_q <= MW'(an_q); nneg_q <= ann_q;
						dmag_q <= MW'(ad_q); dneg_q <= adn_q;
					end
				endcase
				case (op_q)
					ragr_pkg::OP_ADD, ragr_pkg::OP_SUB: begin
						ga_q <= s_mag; gb_q <= MW'(prod);
					end
					ragr_pkg::OP_MUL, ragr_pkg::OP_DIV: begin
						ga_q <= p1_q; gb_q <= p2_q;
					end
					default: begin
						ga_q <= MW'(an_q); gb_q <= MW'(ad_q);
					end
				endcase
				gk_q <= '0;
			end
			ragr_pkg::CMD_GCD_STEP: begin
				// binary GCD: strip shared twos, drop lone twos, halve the odd difference
				case ({ga_q[0], gb_q[0]})
					2'b00: begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						gk_q <= gk_q + 1'b1;
					end
					2'b10: gb_q <= gb_q >> 1;
					2'b01: ga_q <= ga_q >> 1;
					default: begin
						if (ga_q >= gb_q) ga_q <= (ga_q - gb_q) >> 1;
						else gb_q <= (gb_q - ga_q) >> 1;
					end
				endcase
			end
			ragr_pkg::CMD_DIVN_INIT: begin
				ga_q  <= (gsh == '0) ? MW'(1) : gsh;
				dvd_q <= nmag_q;
				rem_q <= '0;
				cnt_q <= CW'(MW);
			end
			ragr_pkg::CMD_DIVD_INIT: begin
				nres_q <= quo_q;
				dvd_q  <= dmag_q;
				rem_q  <= '0;
				cnt_q  <= CW'(MW);
			end
			ragr_pkg::CMD_DIV_STEP: begin
				dvd_q <= {dvd_q[MW-2:0], 1'b0};
				if (!rtry[MW]) begin
					rem_q <= rtry[MW-1:0];
					quo_q <= {quo_q[MW-2:0], 1'b1};
				end else begin
					rem_q <= rsh;
					quo_q <= {quo_q[MW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
			end
			ragr_pkg::CMD_FIN: begin
				out_q.res_num  <= fneg ? (~fn + 1'b1) : fn;
				out_q.res_den  <= fd[MW-2:0];
				out_q.den_zero <= (fd == '0);
			end
			default: ;
		endcase
	end

	assign out_item = out_q;

endmodule

[design/rational_arith_gcd_reduce.sv]
`timescale 1ns / 1ps
// Sequence: after the accepting edge the controller runs the two multiply states and the sum
// state, the binary GCD steps, two restoring divides (numerator, then denominator, by the GCD)
// and the finish state; out_valid then rises in the output state.
// Throughput: one request in flight; the next is taken in the cycle the result is accepted.
// Reset (arst_n low) clears the controller only; the datapath registers are not reset.
module rational_arith_gcd_reduce #(
	parameter int OPERAND_WIDTH = ragr_pkg::OperandWidth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ragr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ragr_pkg::out_item_t out_data
);

	ragr_pkg::cmd_t    cmd;
	ragr_pkg::status_t status;

	ragr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ragr_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk      (clk),
		.in_item  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_item (out_data)
	);

endmodule

[bench/tb_rational_arith_gcd_reduce.sv]
`timescale 1ns / 1ps
module tb_rational_arith_gcd_reduce;

	localparam int  WATCHDOG_LIMIT = 60000;

	class fraction_scoreboard;
		ragr_pkg::out_item_t pending[$];
		int unsigned         errors;

		static function void load(logic [31:0] v, output logic neg, output logic [63:0] mag);
			longint sv;
			sv = longint'(signed'(v));
			neg = sv < 0;
			mag = neg ? 64'(-sv) : 64'(sv);
		endfunction

		static function void smul(logic xn, logic [63:0] xm, logic yn, logic [63:0] ym,
				output logic rn, output logic [63:0] rm);
			rm = xm * ym;
			rn = (xn != yn) && rm != 0;
		endfunction

		static function void sadd(logic xn, logic [63:0] xm, logic yn, logic [63:0] ym,
				output logic rn, output logic [63:0] rm);
			if (xn == yn) begin
				rn = xn; rm = xm + ym;
			end else if (xm >= ym) begin
				rn = xn; rm = xm - ym;
			end else begin
				rn = yn; rm = ym - xm;
			end
			if (rm == 0) rn = 1'b0;
		endfunction

		// raw cross-multiplied numerator and denominator before reduction
		static function void raw_fraction(ragr_pkg::in_item_t it, output logic nn,
				output logic [63:0] nm, output logic dn, output logic [63:0] dm);
			logic ann, adn, bnn, bdn, pn, qn;
			logic [63:0] anm, adm, bnm, bdm, pm, qm;
			load(it.a_num, ann, anm);
			load(it.a_den, adn, adm);
			load(it.b_num, bnn, bnm);
			load(it.b_den, bdn, bdm);
			case (it.op)
				ragr_pkg::OP_ADD, ragr_pkg::OP_SUB: begin
					smul(ann, anm, bdn, bdm, pn, pm);
					smul(bnn, bnm, adn, adm, qn, qm);
					if (it.op == ragr_pkg::OP_SUB && qm != 0) qn = !qn;
					sadd(pn, pm, qn, qm, nn, nm);
					smul(adn, adm, bdn, bdm, dn, dm);
				end
				ragr_pkg::OP_MUL: begin
					smul(ann, anm, bnn, bnm, nn, nm);
					smul(adn, adm, bdn, bdm, dn, dm);
				end
				ragr_pkg::OP_DIV: begin
					smul(ann, anm, bdn, bdm, nn, nm);
					smul(adn, adm, bnn, bnm, dn, dm);
				end
				default: begin
					nn = ann; nm = anm; dn = adn; dm = adm;
				end
			endcase
		endfunction

		static function ragr_pkg::out_item_t reduce(ragr_pkg::in_item_t it);
			logic nn, dn, neg;
			logic [63:0] nm, dm, a, b, t, g;
			ragr_pkg::out_item_t r;
			raw_fraction(it, nn, nm, dn, dm);
			a = nm; b = dm;
			if (a == 0 && b == 0) g = 1;
			else begin
				while (b != 0) begin
					t = a % b; a = b; b = t;
				end
				g = a;
			end
			nm = nm / g;
			dm = dm / g;
			if (nm == 0) neg = 1'b0;
			else if (dm == 0) neg = nn;
			else neg = nn != dn;
			if (nm == 0 && dm != 0) dm = 1;
			r.res_num  = neg ? -nm : nm;
			r.res_den  = dm[62:0];
			r.den_zero = dm == 0;
			return r;
		endfunction

		function void note(ragr_pkg::in_item_t it);
			pending.push_back(reduce(it));
		endfunction

		function void check(ragr_pkg::out_item_t got);
			ragr_pkg::out_item_t exp;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("result with nothing pending: %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp num %0d den %0d dz %0b, got num %0d den %0d dz %0b",
						exp.res_num, exp.res_den, exp.den_zero,
						got.res_num, got.res_den, got.den_zero);
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ragr_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ragr_pkg::out_item_t out_data;

	fraction_scoreboard sb = new();
	int unsigned snd_idle, rcv_idle;
	int unsigned quiet = 0;

	rational_arith_gcd_reduce DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready = $urandom_range(99) >= rcv_idle;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check(out_data);
		if ((out_valid && out_ready) || (in_valid && in_ready) || !arst_n) quiet = 0;
		else quiet++;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("rational_arith_gcd_reduce test failed");
			$finish;
		end
	end

	task automatic send_request(ragr_pkg::in_item_t it);
		while ($urandom_range(99) < snd_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = it;
		do @(posedge clk); while (!in_ready);
		sb.note(it);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [31:0] rand_operand(int unsigned f);
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom_range(20);
			2: v = $urandom >> $urandom_range(31);
			default: v = $urandom_range(1, 1000) * f;
		endcase
		if ($urandom_range(1)) v = -v;
		return v;
	endfunction

	function automatic ragr_pkg::in_item_t rand_request();
		ragr_pkg::in_item_t it;
		int unsigned f;
		f = $urandom_range(1, 1000);
		it.op    = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
		it.a_num = rand_operand(f);
		it.a_den = rand_operand(f);
		it.b_num = rand_operand(f);
		it.b_den = rand_operand(f);
		return it;
	endfunction

	function automatic ragr_pkg::in_item_t mk(ragr_pkg::op_t op, int an, int ad, int bn, int bd);
		ragr_pkg::in_item_t it;
		it.op = op; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
		return it;
	endfunction

	task automatic run_directed();
		ragr_pkg::in_item_t d[$];
		ragr_pkg::in_item_t it;
		d.push_back(mk(ragr_pkg::OP_ADD, 1, 2, 1, 3));
		d.push_back(mk(ragr_pkg::OP_SUB, 1, 2, 1, 2));
		d.push_back(mk(ragr_pkg::OP_SUB, -3, 4, 5, -6));
		d.push_back(mk(ragr_pkg::OP_MUL, -6, 8, 4, -9));
		d.push_back(mk(ragr_pkg::OP_DIV, 2, 3, 4, 5));
		d.push_back(mk(ragr_pkg::OP_DIV, 2, 3, 0, 5));
		d.push_back(mk(ragr_pkg::OP_RED, 12, -18, 7, 7));
		d.push_back(mk(ragr_pkg::OP_RED, 0, -5, 0, 0));
		d.push_back(mk(ragr_pkg::OP_RED, -7, 0, 0, 0));
		d.push_back(mk(ragr_pkg::OP_RED, 0, 0, 0, 0));
		d.push_back(mk(ragr_pkg::OP_ADD, 0, 0, 3, 4));
		d.push_back(mk(ragr_pkg::OP_RED, 32'h8000_0000, 32'h8000_0000, 0, 1));
		d.push_back(mk(ragr_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000));
		d.push_back(mk(ragr_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000));
		d.push_back(mk(ragr_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff));
		d.push_back(mk(ragr_pkg::OP_SUB, 32'h7fff_ffff, 32'h7fff_fffe,
			32'h7fff_fffe, 32'h7fff_fffd));
		d.push_back(mk(ragr_pkg::OP_DIV, -32'sh7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, -32'sh7fff_ffff));
		for (int k = 5; k <= 7; k++) begin
			it = mk(ragr_pkg::OP_RED, 10, -4, 1, 1);
			it.op = 3'(k);
			d.push_back(it);
		end
		foreach (d[i]) send_request(d[i]);
	endtask

	initial begin
		snd_idle = 12;
		rcv_idle = 87;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();
		repeat (430) send_request(rand_request());

		snd_idle = 87;
		rcv_idle = 12;
		repeat (450) send_request(rand_request());

		// hold off until the block has drained
		while (sb.pending.size() != 0) @(negedge clk);
		snd_idle = 0;
		rcv_idle = 0;
		repeat (450) send_request(rand_request());

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("rational_arith_gcd_reduce test passed");
		else
			$display("rational_arith_gcd_reduce test failed");
		$finish;
	end
endmodule
